>>> design/lcdv_pkg.sv
package lcdv_pkg;

    // Command codes carried by a request
    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_EOL   = 3'd2,
        CMD_MODE  = 3'd3,
        CMD_VOL   = 3'd4
    } t_cmd;

    // Register ports
    localparam logic [7:0] PORT_CTRL     = 8'h00;
    localparam logic [7:0] PORT_BACKDROP = 8'h01;
    localparam logic [7:0] PORT_LINE     = 8'h02;
    localparam logic [7:0] PORT_LCMP     = 8'h03;
    localparam logic [7:0] PORT_SPR_BASE = 8'h04;
    localparam logic [7:0] PORT_SPR_FRST = 8'h05;
    localparam logic [7:0] PORT_SPR_CNT  = 8'h06;
    localparam logic [7:0] PORT_MAP_BASE = 8'h07;
    localparam logic [7:0] PORT_WIN_LO   = 8'h08;
    localparam logic [7:0] PORT_WIN_HI   = 8'h13;
    localparam logic [7:0] PORT_LCD_CTRL = 8'h14;
    localparam logic [7:0] PORT_ICON     = 8'h15;
    localparam logic [7:0] PORT_LAST_LN  = 8'h16;
    localparam logic [7:0] PORT_BPORCH   = 8'h17;
    localparam logic [7:0] PORT_LCD_STAT = 8'h1A;

    // Masks
    localparam logic [7:0] MASK_BACKDROP_MONO = 8'h07;
    localparam logic [5:0] MASK_SPR_BASE_MONO = 6'h1F;
    localparam logic [7:0] MASK_MAP_MONO      = 8'h77;

    // Reset values and line timing
    localparam logic [7:0] RST_LAST_LINE  = 8'd158;
    localparam logic [7:0] RST_BACK_PORCH = 8'd155;
    localparam logic [7:0] LINE_NO_VIDEO  = 8'd255;
    localparam logic [8:0] LINE_VBLANK    = 9'd144;
    localparam logic [8:0] LINE_HANDOVER  = 9'd145;
    localparam int         VOL_WIN_LOG2   = 7;    // 128 frame window

    // Frame blanking codes
    localparam logic [1:0] BLANK_NONE  = 2'd0;
    localparam logic [1:0] BLANK_WHITE = 2'd1;
    localparam logic [1:0] BLANK_TAIL  = 2'd2;

    // Configuration port
    localparam int         APB_AW       = 3;
    localparam int         APB_DW       = 32;
    localparam logic       CFG_COLOR    = 1'b0;
    localparam logic       CFG_HEADPHON = 1'b1;

    // Palette memory: one row holds a pair of 3-bit entries
    localparam int PAL_W = 6;
    localparam int PAL_D = 32;

    // Write request from the item stage to the register file
    typedef struct packed {
        logic       en;
        logic [7:0] port;
        logic [7:0] data;
    } t_port_wr;

    // Register file state needed by the line timing
    typedef struct packed {
        logic       lcd_on;
        logic       sleep;
        logic [7:0] last_line;
        logic [7:0] line_cmp;
    } t_lcd_stat;

    // Master volume to status level
    function automatic logic [1:0] vol_level(input logic color, input logic [1:0] vol);
        logic [1:0] lvl;
        case (vol)
            2'd0:    lvl = 2'd0;
            2'd1:    lvl = 2'd2;
            2'd2:    lvl = color ? 2'd1 : 2'd3;
            2'd3:    lvl = color ? 2'd3 : 2'd0;
            default: lvl = 2'd0;
        endcase
        return lvl;
    endfunction

endpackage

>>> design/lcdv_if.sv
interface lcdv_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] port;
    logic [7:0] write_data;
    logic [1:0] master_volume;

    modport source (output valid, command, port, write_data, master_volume, input ready);
    modport sink   (input valid, command, port, write_data, master_volume, output ready);
endinterface

interface lcdv_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       line_irq;
    logic       frame_done;
    logic [1:0] frame_blank;
    logic       frame_start;
    logic [1:0] current_mode;

    modport source (output valid, read_data, vblank_irq, line_irq, frame_done, frame_blank,
                    frame_start, current_mode, input ready);
    modport sink   (input valid, read_data, vblank_irq, line_irq, frame_done, frame_blank,
                    frame_start, current_mode, output ready);
endinterface

>>> design/lcdv_ram.sv
module lcdv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> design/lcdv_regs.sv
module lcdv_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_is_color,
    input  logic               i_headphone,
    input  logic               i_acc,
    input  logic [7:0]         i_acc_port,
    input  lcdv_pkg::t_port_wr i_wr,
    input  logic [7:0]         i_rd_port,
    input  logic [1:0]         i_vol,
    input  logic [7:0]         i_line_lo,
    input  logic               i_vol_window,
    output logic [7:0]         o_rd_data,
    output lcdv_pkg::t_lcd_stat o_stat
);
    import lcdv_pkg::*;

    logic [5:0] r_ctrl;
    logic [7:0] r_backdrop;
    logic [7:0] r_lcmp;
    logic [5:0] r_spr_base;
    logic [6:0] r_spr_first;
    logic [7:0] r_spr_cnt;
    logic [7:0] r_map_base;
    logic [7:0] r_win [12];
    logic [2:0] r_lcd_flags;   // bit0 enable, bit1 high contrast, bit2 sleep
    logic [5:0] r_icon;
    logic [7:0] r_last_line;
    logic [7:0] r_back_porch;
    logic [7:0] r_shade [4];   // two 4-bit entries per row
    logic [PAL_D-1:0] r_pal_vld;
    logic             r_pal_rd_vld;
    logic             r_pal_byp_v;
    logic [PAL_W-1:0] r_pal_byp;

    logic [PAL_W-1:0] pal_q;
    logic [PAL_W-1:0] pal_row;
    logic [PAL_W-1:0] pal_wdata;
    logic             wr_pal;
    logic             wr_win;
    logic             wr_shade;
    logic             byp_hit;
    logic [3:0]       wr_widx;
    logic [3:0]       rd_widx;
    logic             rd_win;
    logic [7:0]       stat_byte;

    // Range decode
    assign wr_win   = i_wr.en && (i_wr.port >= PORT_WIN_LO) && (i_wr.port <= PORT_WIN_HI);
    assign wr_shade = i_wr.en && (i_wr.port[7:2] == 6'b000111);
    assign wr_pal   = i_wr.en && (i_wr.port[7:5] == 3'b001);
    assign wr_widx  = 4'(i_wr.port - PORT_WIN_LO);
    assign rd_win   = (i_rd_port >= PORT_WIN_LO) && (i_rd_port <= PORT_WIN_HI);
    assign rd_widx  = 4'(i_rd_port - PORT_WIN_LO);
    assign pal_wdata = {i_wr.data[6:4], i_wr.data[2:0]};

    // Palette memory, read issued when the item is accepted
    lcdv_ram #(.WIDTH(PAL_W), .DEPTH(PAL_D)) u_pal (
        .i_clk   (i_clk),
        .i_we    (wr_pal),
        .i_waddr (i_wr.port[4:0]),
        .i_wdata (pal_wdata),
        .i_re    (i_acc),
        .i_raddr (i_acc_port[4:0]),
        .o_rdata (pal_q)
    );

    // Forward a write that lands on the row being read in the same cycle
    assign byp_hit = wr_pal && (i_wr.port[4:0] == i_acc_port[4:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld    <= '0;
            r_pal_rd_vld <= 1'b0;
            r_pal_byp_v  <= 1'b0;
        end else begin
            if (wr_pal) begin
                r_pal_vld[i_wr.port[4:0]] <= 1'b1;
            end
            if (i_acc) begin
                r_pal_rd_vld <= r_pal_vld[i_acc_port[4:0]] | byp_hit;
                r_pal_byp_v  <= byp_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && byp_hit) begin
            r_pal_byp <= pal_wdata;
        end
    end

    assign pal_row = !r_pal_rd_vld ? '0 : (r_pal_byp_v ? r_pal_byp : pal_q);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl       <= '0;
            r_backdrop   <= '0;
            r_lcmp       <= '0;
            r_spr_base   <= '0;
            r_spr_first  <= '0;
            r_spr_cnt    <= '0;
            r_map_base   <= '0;
            r_lcd_flags  <= '0;
            r_icon       <= '0;
            r_last_line  <= RST_LAST_LINE;
            r_back_porch <= RST_BACK_PORCH;
            for (int k = 0; k < 12; k++) begin
                r_win[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_shade[k] <= '0;
            end
        end else if (i_wr.en) begin
            if (wr_win) begin
                r_win[wr_widx] <= i_wr.data;
            end
            if (wr_shade) begin
                r_shade[i_wr.port[1:0]] <= i_wr.data;
            end
            case (i_wr.port)
                PORT_CTRL:     r_ctrl <= i_wr.data[5:0];
                PORT_BACKDROP: r_backdrop <= i_is_color ? i_wr.data
                                                        : (i_wr.data & MASK_BACKDROP_MONO);
                PORT_LCMP:     r_lcmp <= i_wr.data;
                PORT_SPR_BASE: r_spr_base <= i_is_color ? i_wr.data[5:0]
                                                        : (i_wr.data[5:0] & MASK_SPR_BASE_MONO);
                PORT_SPR_FRST: r_spr_first <= i_wr.data[6:0];
                PORT_SPR_CNT:  r_spr_cnt <= i_wr.data;
                PORT_MAP_BASE: r_map_base <= i_is_color ? i_wr.data
                                                        : (i_wr.data & MASK_MAP_MONO);
                PORT_LCD_CTRL: begin
                    r_lcd_flags[0] <= i_wr.data[0];
                    if (i_is_color) begin
                        r_lcd_flags[1] <= i_wr.data[1];
                    end
                end
                PORT_ICON:     r_icon <= i_wr.data[5:0];
                PORT_LAST_LN:  r_last_line <= i_wr.data;
                PORT_BPORCH: begin
                    if (i_is_color) begin
                        r_back_porch <= i_wr.data;
                    end
                end
                PORT_LCD_STAT: r_lcd_flags[2] <= i_wr.data[0];
                default: ;
            endcase
        end
    end

    // LCD status byte
    always_comb begin
        stat_byte = {7'b0, r_lcd_flags[2]};
        if (i_vol_window) begin
            stat_byte = stat_byte | (i_headphone ? 8'h02 : 8'h10);
        end
        stat_byte = stat_byte | {4'b0, vol_level(i_is_color, i_vol), 2'b0};
    end

    // Read mux
    always_comb begin
        if (rd_win) begin
            o_rd_data = r_win[rd_widx];
        end else if (i_rd_port[7:2] == 6'b000111) begin
            o_rd_data = r_shade[i_rd_port[1:0]];
        end else if (i_rd_port[7:5] == 3'b001) begin
            o_rd_data = {1'b0, pal_row[5:3], 1'b0, pal_row[2:0]};
        end else begin
            case (i_rd_port)
                PORT_CTRL:     o_rd_data = {2'b0, r_ctrl};
                PORT_BACKDROP: o_rd_data = i_is_color ? r_backdrop
                                                      : (r_backdrop & MASK_BACKDROP_MONO);
                PORT_LINE:     o_rd_data = i_line_lo;
                PORT_LCMP:     o_rd_data = r_lcmp;
                PORT_SPR_BASE: o_rd_data = {2'b0, i_is_color ? r_spr_base
                                                             : (r_spr_base & MASK_SPR_BASE_MONO)};
                PORT_SPR_FRST: o_rd_data = {1'b0, r_spr_first};
                PORT_SPR_CNT:  o_rd_data = r_spr_cnt;
                PORT_MAP_BASE: o_rd_data = i_is_color ? r_map_base
                                                      : (r_map_base & MASK_MAP_MONO);
                PORT_LCD_CTRL: o_rd_data = {6'b0, r_lcd_flags[1:0]};
                PORT_ICON:     o_rd_data = {2'b0, r_icon};
                PORT_LAST_LN:  o_rd_data = r_last_line;
                PORT_BPORCH:   o_rd_data = r_back_porch;
                PORT_LCD_STAT: o_rd_data = stat_byte;
                default:       o_rd_data = 8'h00;
            endcase
        end
    end

    assign o_stat.lcd_on    = r_lcd_flags[0];
    assign o_stat.sleep     = r_lcd_flags[2];
    assign o_stat.last_line = r_last_line;
    assign o_stat.line_cmp  = r_lcmp;

endmodule

>>> design/lcd_video_register_and_line_timing.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    command, port, write_data, master_volume
// o_rsp     out  valid/ready    read_data, irqs, frame_done/blank/start, current_mode
// apb       in   psel/penable   is_color_model (0x0), headphone_mode (0x4)
//
// One request per cycle sustained; the request is held in an item stage, decoded
// in one pass, and its result lands in the output register.
// The palette read is issued at accept so its registered data meets the stage.
// Reset is synchronous; palette rows read as zero through per-row valid bits.
// A stalled result holds the stage, and the input takes a request only while
// the stage is empty or moving on.
module lcd_video_register_and_line_timing (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lcdv_req_if.sink                     i_req,
    lcdv_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcdv_pkg::APB_AW-1:0]  paddr,
    input  logic [lcdv_pkg::APB_DW-1:0]  pwdata,
    output logic [lcdv_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lcdv_pkg::*;

    // Configuration
    logic r_is_color;
    logic r_headphone;

    // Item stage
    logic       r_stg_v;
    logic [2:0] r_stg_cmd;
    logic [7:0] r_stg_port;
    logic [7:0] r_stg_data;
    logic [1:0] r_stg_vol;

    // Line timing state
    logic [8:0]  r_line;
    logic [31:0] r_frame_cnt;
    logic [31:0] r_vol_frame;
    logic [1:0]  r_mode_cur;
    logic [1:0]  r_mode_next;

    // Result register
    logic       r_out_v;
    logic [7:0] r_read_data;
    logic       r_vblank;
    logic       r_line_irq;
    logic       r_frame_done;
    logic [1:0] r_frame_blank;
    logic       r_frame_start;

    logic       acc;
    logic       fire;
    logic       cfg_wr;
    t_port_wr   port_wr;
    t_lcd_stat  stat;
    logic [7:0] rd_data;
    logic [32:0] vol_diff;
    logic       vol_window;
    t_cmd       cmd;

    logic [8:0] line_inc;
    logic       wrap;
    logic [8:0] n_line;
    logic       n_vblank;
    logic       n_line_irq;
    logic       n_frame_done;
    logic [1:0] n_frame_blank;
    logic [1:0] blank_code;

    // Handshake
    assign fire        = r_stg_v && (!r_out_v || o_rsp.ready);
    assign i_req.ready = !r_stg_v || fire;
    assign acc         = i_req.valid && i_req.ready;
    assign cmd         = t_cmd'(r_stg_cmd);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[APB_AW-1] == CFG_HEADPHON) ? APB_DW'(r_headphone)
                                                      : APB_DW'(r_is_color);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_color  <= 1'b0;
            r_headphone <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[APB_AW-1] == CFG_HEADPHON) begin
                r_headphone <= pwdata[0];
            end else begin
                r_is_color <= pwdata[0];
            end
        end
    end

    // Item stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= 1'b0;
        end else if (acc) begin
            r_stg_v <= 1'b1;
        end else if (fire) begin
            r_stg_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stg_cmd  <= i_req.command;
            r_stg_port <= i_req.port;
            r_stg_data <= i_req.write_data;
            r_stg_vol  <= i_req.master_volume;
        end
    end

    // Register file
    assign port_wr.en   = fire && (cmd == CMD_WRITE);
    assign port_wr.port = r_stg_port;
    assign port_wr.data = r_stg_data;

    lcdv_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_is_color   (r_is_color),
        .i_headphone  (r_headphone),
        .i_acc        (acc),
        .i_acc_port   (i_req.port),
        .i_wr         (port_wr),
        .i_rd_port    (r_stg_port),
        .i_vol        (r_stg_vol),
        .i_line_lo    (r_line[7:0]),
        .i_vol_window (vol_window),
        .o_rd_data    (rd_data),
        .o_stat       (stat)
    );

    // Volume icon window: shown frame not ahead and under 128 frames behind
    assign vol_diff   = {1'b0, r_frame_cnt} - {1'b0, r_vol_frame};
    assign vol_window = !vol_diff[32] && (vol_diff[31:VOL_WIN_LOG2] == '0);

    // Blanking of a handed-over frame
    always_comb begin
        if (stat.sleep || !stat.lcd_on || (stat.last_line == LINE_NO_VIDEO)) begin
            blank_code = BLANK_WHITE;
        end else if ({1'b0, stat.last_line} < LINE_VBLANK) begin
            blank_code = BLANK_TAIL;
        end else begin
            blank_code = BLANK_NONE;
        end
    end

    // End of line
    always_comb begin
        line_inc   = r_line + 9'd1;
        wrap       = line_inc > {1'b0, stat.last_line};
        n_line     = wrap ? 9'd0 : line_inc;
        n_vblank   = !wrap && (line_inc == LINE_VBLANK);
        n_frame_done = wrap ? (line_inc <= LINE_HANDOVER) : (line_inc == LINE_HANDOVER);
        n_line_irq = (n_line == {1'b0, stat.line_cmp});
        n_frame_blank = n_frame_done ? blank_code : BLANK_NONE;
    end

    // Line timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_frame_cnt <= '0;
            r_vol_frame <= '1;
            r_mode_cur  <= '0;
            r_mode_next <= '0;
        end else if (fire) begin
            case (cmd)
                CMD_EOL: begin
                    r_line <= n_line;
                    if (n_frame_done) begin
                        r_frame_cnt <= r_frame_cnt + 32'd1;
                    end
                    if (wrap) begin
                        r_mode_cur <= r_mode_next;
                    end
                end
                CMD_MODE: r_mode_next <= r_stg_data[1:0];
                CMD_VOL:  r_vol_frame <= r_frame_cnt;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (fire) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data   <= (cmd == CMD_READ) ? rd_data : 8'h00;
            r_vblank      <= (cmd == CMD_EOL) && n_vblank;
            r_line_irq    <= (cmd == CMD_EOL) && n_line_irq;
            r_frame_done  <= (cmd == CMD_EOL) && n_frame_done;
            r_frame_blank <= (cmd == CMD_EOL) ? n_frame_blank : BLANK_NONE;
            r_frame_start <= (cmd == CMD_EOL) && wrap;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.read_data    = r_read_data;
    assign o_rsp.vblank_irq   = r_vblank;
    assign o_rsp.line_irq     = r_line_irq;
    assign o_rsp.frame_done   = r_frame_done;
    assign o_rsp.frame_blank  = r_frame_blank;
    assign o_rsp.frame_start  = r_frame_start;
    // Mode after the item: current mode register, stable while the result waits
    assign o_rsp.current_mode = r_mode_cur;

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdv_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int QUIET_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 390;

    // Ports and codes the package leaves unnamed
    localparam logic [7:0] PORT_SHADE_LO = 8'h1C;
    localparam logic [7:0] PORT_SHADE_HI = 8'h1F;
    localparam logic [7:0] PORT_PAL_LO   = 8'h20;
    localparam logic [7:0] PORT_PAL_HI   = 8'h3F;
    localparam logic [7:0] PORT_UNUSED   = 8'hFF;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    localparam logic [APB_AW-1:0] CFG_ADDR_COLOR     = {CFG_COLOR, 2'b00};
    localparam logic [APB_AW-1:0] CFG_ADDR_HEADPHONE = {CFG_HEADPHON, 2'b00};

    // LCD flag bits and status bits
    localparam int         FLAG_ENABLE    = 0;
    localparam int         FLAG_CONTRAST  = 1;
    localparam int         FLAG_SLEEP     = 2;
    localparam logic [7:0] STAT_SPEAKER   = 8'h10;
    localparam logic [7:0] STAT_HEADPHONE = 8'h02;
    localparam logic [31:0] VOLUME_WINDOW = 32'd1 << VOL_WIN_LOG2;

    // Master volume to status level, two bits per volume step, step 0 lowest
    localparam logic [7:0] MONO_LEVELS  = {2'd0, 2'd3, 2'd2, 2'd0};
    localparam logic [7:0] COLOR_LEVELS = {2'd3, 2'd1, 2'd2, 2'd0};

    // Model/audio setting per phase: bit 1 color model, bit 0 headphones
    localparam logic [2*PHASES-1:0] PHASE_SETTINGS = {2'b00, 2'b11, 2'b01, 2'b10};

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] port;
        logic [7:0] data;
        logic [1:0] volume;
    } t_request;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank;
        logic       line_hit;
        logic       frame_done;
        logic [1:0] blank;
        logic       frame_start;
        logic [1:0] mode;
    } t_video_result;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] port;
        logic [7:0] data;
        logic [1:0] volume;
        logic       typed;
        logic [7:0] typed_read;
    } t_opening_row;

    // Opening requests; typed reads are values that follow from reset, the masks and the requests before them
    localparam int OPENING_COUNT = 26;
    localparam t_opening_row OPENING_ROWS [OPENING_COUNT] = '{
        '{CMD_READ,  PORT_LAST_LN,  8'h00, 2'd0, 1'b1, RST_LAST_LINE},
        '{CMD_READ,  PORT_BPORCH,   8'h00, 2'd0, 1'b1, RST_BACK_PORCH},
        '{CMD_READ,  PORT_LINE,     8'h00, 2'd0, 1'b1, 8'h00},
        '{CMD_READ,  PORT_LCD_STAT, 8'h00, 2'd3, 1'b1, 8'h00},
        '{CMD_READ,  PORT_LCD_STAT, 8'h00, 2'd2, 1'b1, 8'h0C},
        '{CMD_WRITE, PORT_BACKDROP, 8'hFF, 2'd0, 1'b0, 8'h00},
        '{CMD_READ,  PORT_BACKDROP, 8'h00, 2'd0, 1'b1, MASK_BACKDROP_MONO},
        '{CMD_WRITE, PORT_MAP_BASE, 8'hFF, 2'd1, 1'b0, 8'h00},
        '{CMD_READ,  PORT_MAP_BASE, 8'h00, 2'd1, 1'b1, MASK_MAP_MONO},
        '{CMD_WRITE, PORT_SPR_BASE, 8'hFF, 2'd2, 1'b0, 8'h00},
        '{CMD_READ,  PORT_SPR_BASE, 8'h00, 2'd2, 1'b1, {2'b00, MASK_SPR_BASE_MONO}},
        '{CMD_WRITE, PORT_LINE,     8'hFF, 2'd3, 1'b0, 8'h00},
        '{CMD_READ,  PORT_LINE,     8'hFF, 2'd3, 1'b1, 8'h00},
        '{CMD_WRITE, PORT_UNUSED,   8'hFF, 2'd0, 1'b0, 8'h00},
        '{CMD_READ,  PORT_UNUSED,   8'hFF, 2'd0, 1'b1, 8'h00},
        '{CMD_WRITE, PORT_BPORCH,   8'h00, 2'd0, 1'b0, 8'h00},
        '{CMD_READ,  PORT_BPORCH,   8'h00, 2'd0, 1'b1, RST_BACK_PORCH},
        '{CMD_WRITE, PORT_LCD_CTRL, 8'hFF, 2'd0, 1'b0, 8'h00},
        '{CMD_READ,  PORT_LCD_CTRL, 8'h00, 2'd0, 1'b1, 8'h01},
        '{CMD_MODE,  PORT_UNUSED,   8'hFF, 2'd0, 1'b0, 8'h00},
        '{CMD_WRITE, PORT_LAST_LN,  8'h00, 2'd0, 1'b0, 8'h00},
        '{CMD_VOL,   8'h00,         8'h00, 2'd0, 1'b0, 8'h00},
        '{CMD_EOL,   8'h00,         8'h00, 2'd0, 1'b0, 8'h00},
        '{CMD_READ,  PORT_LCD_STAT, 8'h00, 2'd1, 1'b1, 8'h18},
        '{CMD_WRITE, PORT_LCD_STAT, 8'h01, 2'd0, 1'b0, 8'h00},
        '{CMD_UNUSED, PORT_UNUSED,  8'hFF, 2'd3, 1'b0, 8'h00}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lcdv_req_if req_ch ();
    lcdv_rsp_if rsp_ch ();

    lcd_video_register_and_line_timing u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the video unit's registers and line timing
    logic        is_color  = 1'b0;
    logic        headphone = 1'b0;
    logic [5:0]  ctrl_q      = '0;
    logic [7:0]  backdrop_q  = '0;
    logic [7:0]  lcmp_q      = '0;
    logic [5:0]  spr_base_q  = '0;
    logic [6:0]  spr_first_q = '0;
    logic [7:0]  spr_cnt_q   = '0;
    logic [7:0]  map_q       = '0;
    logic [7:0]  scroll_q [12] = '{default: '0};
    logic [2:0]  lcd_flags_q = '0;
    logic [5:0]  icon_q      = '0;
    logic [7:0]  last_line_q = RST_LAST_LINE;
    logic [7:0]  porch_q     = RST_BACK_PORCH;
    logic [3:0]  shade_q [8]  = '{default: '0};
    logic [2:0]  pal_q [64]   = '{default: '0};
    logic [8:0]  line_q      = '0;
    logic [31:0] frames_q    = '0;
    logic [31:0] vol_frame_q = '1;
    logic [1:0]  mode_cur    = '0;
    logic [1:0]  mode_next   = '0;

    t_video_result pending_results [$];

    bit req_steady;
    bit rsp_steady;
    int mismatches;
    int requests_done;
    int results_checked;
    int quiet_cycles;
    int frames_handed;
    int frames_blanked;
    int wraps_seen;
    int vblanks_seen;
    int line_hits_seen;
    int window_reads;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("result %0d: %s mismatch, got %0h expected %0h",
                 results_checked, what, got, want);
    endtask

    // Frame goes to the display: pick the blanking and count the frame
    function automatic logic [1:0] hand_over_frame();
        logic [1:0] blank;
        blank = BLANK_NONE;
        if (lcd_flags_q[FLAG_SLEEP] || !lcd_flags_q[FLAG_ENABLE] ||
            last_line_q == LINE_NO_VIDEO) begin
            blank = BLANK_WHITE;
        end else if (last_line_q < LINE_VBLANK) begin
            blank = BLANK_TAIL;
        end
        frames_q = frames_q + 32'd1;
        frames_handed++;
        if (blank != BLANK_NONE) frames_blanked++;
        return blank;
    endfunction

    // Expected result of one accepted request; updates the shadow state
    function automatic t_video_result video_unit_step(input t_request r);
        t_video_result res;
        logic [1:0]    level;
        int            idx;
        res = '0;
        case (r.command)
            CMD_WRITE: begin
                if (r.port >= PORT_WIN_LO && r.port <= PORT_WIN_HI) begin
                    scroll_q[r.port - PORT_WIN_LO] = r.data;
                end else if (r.port >= PORT_SHADE_LO && r.port <= PORT_SHADE_HI) begin
                    idx = 2 * (r.port - PORT_SHADE_LO);
                    shade_q[idx]     = r.data[3:0];
                    shade_q[idx + 1] = r.data[7:4];
                end else if (r.port >= PORT_PAL_LO && r.port <= PORT_PAL_HI) begin
                    idx = 2 * (r.port - PORT_PAL_LO);
                    pal_q[idx]     = r.data[2:0];
                    pal_q[idx + 1] = r.data[6:4];
                end else begin
                    case (r.port)
                        PORT_CTRL:     ctrl_q = r.data[5:0];
                        PORT_BACKDROP: backdrop_q = r.data & (is_color ? 8'hFF : MASK_BACKDROP_MONO);
                        PORT_LCMP:     lcmp_q = r.data;
                        PORT_SPR_BASE: spr_base_q = r.data[5:0] &
                                                    (is_color ? 6'h3F : MASK_SPR_BASE_MONO);
                        PORT_SPR_FRST: spr_first_q = r.data[6:0];
                        PORT_SPR_CNT:  spr_cnt_q = r.data;
                        PORT_MAP_BASE: map_q = r.data & (is_color ? 8'hFF : MASK_MAP_MONO);
                        PORT_LCD_CTRL: begin
                            lcd_flags_q[FLAG_ENABLE] = r.data[0];
                            // high contrast exists on the color model only
                            if (is_color) lcd_flags_q[FLAG_CONTRAST] = r.data[1];
                        end
                        PORT_ICON:     icon_q = r.data[5:0];
                        PORT_LAST_LN:  last_line_q = r.data;
                        PORT_BPORCH:   if (is_color) porch_q = r.data;
                        PORT_LCD_STAT: lcd_flags_q[FLAG_SLEEP] = r.data[0];
                        default: ;
                    endcase
                end
            end
            CMD_READ: begin
                if (r.port >= PORT_WIN_LO && r.port <= PORT_WIN_HI) begin
                    res.read_data = scroll_q[r.port - PORT_WIN_LO];
                end else if (r.port >= PORT_SHADE_LO && r.port <= PORT_SHADE_HI) begin
                    idx = 2 * (r.port - PORT_SHADE_LO);
                    res.read_data = {shade_q[idx + 1], shade_q[idx]};
                end else if (r.port >= PORT_PAL_LO && r.port <= PORT_PAL_HI) begin
                    idx = 2 * (r.port - PORT_PAL_LO);
                    res.read_data = {1'b0, pal_q[idx + 1], 1'b0, pal_q[idx]};
                end else begin
                    case (r.port)
                        PORT_CTRL:     res.read_data = {2'b00, ctrl_q};
                        PORT_BACKDROP: res.read_data = backdrop_q &
                                                       (is_color ? 8'hFF : MASK_BACKDROP_MONO);
                        PORT_LINE:     res.read_data = line_q[7:0];
                        PORT_LCMP:     res.read_data = lcmp_q;
                        PORT_SPR_BASE: res.read_data = {2'b00, spr_base_q &
                                                       (is_color ? 6'h3F : MASK_SPR_BASE_MONO)};
                        PORT_SPR_FRST: res.read_data = {1'b0, spr_first_q};
                        PORT_SPR_CNT:  res.read_data = spr_cnt_q;
                        PORT_MAP_BASE: res.read_data = map_q & (is_color ? 8'hFF : MASK_MAP_MONO);
                        PORT_LCD_CTRL: res.read_data = {6'b0, lcd_flags_q[1:0]};
                        PORT_ICON:     res.read_data = {2'b00, icon_q};
                        PORT_LAST_LN:  res.read_data = last_line_q;
                        PORT_BPORCH:   res.read_data = porch_q;
                        PORT_LCD_STAT: begin
                            level = is_color ? COLOR_LEVELS[r.volume * 2 +: 2]
                                             : MONO_LEVELS[r.volume * 2 +: 2];
                            res.read_data = {4'b0, level, 1'b0, lcd_flags_q[FLAG_SLEEP]};
                            // icon shown for a window of frames after the button press
                            if (vol_frame_q <= frames_q &&
                                (frames_q - vol_frame_q) < VOLUME_WINDOW) begin
                                res.read_data |= headphone ? STAT_HEADPHONE : STAT_SPEAKER;
                                window_reads++;
                            end
                        end
                        default: res.read_data = '0;
                    endcase
                end
            end
            CMD_EOL: begin
                line_q = line_q + 9'd1;
                if (line_q > {1'b0, last_line_q}) begin
                    // short frames are handed over at the wrap itself
                    if (line_q <= LINE_HANDOVER) begin
                        res.frame_done = 1'b1;
                        res.blank      = hand_over_frame();
                    end
                    mode_cur = mode_next;
                    line_q   = '0;
                    res.frame_start = 1'b1;
                    wraps_seen++;
                end else if (line_q == LINE_HANDOVER) begin
                    res.frame_done = 1'b1;
                    res.blank      = hand_over_frame();
                end else if (line_q == LINE_VBLANK) begin
                    res.vblank = 1'b1;
                    vblanks_seen++;
                end
                if (line_q == {1'b0, lcmp_q}) begin
                    res.line_hit = 1'b1;
                    line_hits_seen++;
                end
            end
            CMD_MODE: mode_next = r.data[1:0];
            CMD_VOL:  vol_frame_q = frames_q;
            default: ;
        endcase
        res.mode = mode_cur;
        return res;
    endfunction

    function automatic t_request make_request(input logic [2:0] command,
                                              input logic [7:0] port,
                                              input logic [7:0] data);
        t_request r;
        r.command = command;
        r.port    = port;
        r.data    = data;
        r.volume  = 2'($urandom);
        return r;
    endfunction

    // Register traffic over the whole port space, mostly the mapped part
    function automatic t_request random_access();
        t_request r;
        int       pick;
        r.port   = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                              : 8'($urandom_range(0, PORT_PAL_HI));
        r.data   = 8'($urandom);
        r.volume = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) r.command = CMD_WRITE;
        else if (pick < 90) r.command = CMD_READ;
        else if (pick < 95) r.command = CMD_MODE;
        else if (pick < 97) r.command = CMD_VOL;
        else r.command = 3'(CMD_VOL) + 3'($urandom_range(1, 3));
        return r;
    endfunction

    // Drive one request, wait for its acceptance and queue what it should return
    task automatic push_request(input t_request r, input logic typed,
                                input logic [7:0] typed_read);
        t_video_result want;
        int            gap;
        gap = req_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= r.command;
        req_ch.port          <= r.port;
        req_ch.write_data    <= r.data;
        req_ch.master_volume <= r.volume;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        want = video_unit_step(r);
        if (typed) want.read_data = typed_read;
        pending_results.push_back(want);
        requests_done++;
    endtask

    task automatic run_items(input int count, input int eol_pct, input bit status_reads);
        t_request r;
        repeat (count) begin
            if ($urandom_range(0, 99) < eol_pct) begin
                r = make_request(CMD_EOL, 8'($urandom), 8'($urandom));
            end else if (status_reads) begin
                r = make_request(CMD_READ, PORT_LCD_STAT, 8'($urandom));
            end else begin
                r = random_access();
            end
            push_request(r, 1'b0, 8'h00);
        end
    endtask

    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle, then the bus goes idle so writes never abut
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{(APB_DW - 1){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CFG_ADDR_COLOR) is_color = value;
        else headphone = value;
        @(posedge i_clk);
    endtask

    // Stimulus: directed opening, then random segments under each setting
    initial begin : stimulus
        t_request   r;
        logic [1:0] setting;
        logic [7:0] value;
        int         phase_start;
        int         kind;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.command       <= '0;
        req_ch.port          <= '0;
        req_ch.write_data    <= '0;
        req_ch.master_volume <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_write(CFG_ADDR_COLOR, 1'b0);
        apb_write(CFG_ADDR_HEADPHONE, 1'b0);

        for (int i = 0; i < OPENING_COUNT; i++) begin
            r = '{OPENING_ROWS[i].command, OPENING_ROWS[i].port,
                  OPENING_ROWS[i].data, OPENING_ROWS[i].volume};
            push_request(r, OPENING_ROWS[i].typed, OPENING_ROWS[i].typed_read);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            setting = PHASE_SETTINGS[ph * 2 +: 2];
            wait_until_idle();
            apb_write(CFG_ADDR_COLOR, setting[1]);
            apb_write(CFG_ADDR_HEADPHONE, setting[0]);
            phase_start = requests_done;
            while (requests_done - phase_start < PHASE_ITEMS) begin
                req_steady = ($urandom_range(0, 3) == 0);
                rsp_steady = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 35) begin
                    // full frames through vblank, handover and the wrap
                    case ($urandom_range(0, 3))
                        0: value = LINE_NO_VIDEO;
                        1: value = 8'($urandom_range(LINE_VBLANK - 1, LINE_HANDOVER + 1));
                        2: value = RST_LAST_LINE;
                        default: value = 8'($urandom_range(LINE_VBLANK - 4, 200));
                    endcase
                    push_request(make_request(CMD_WRITE, PORT_LAST_LN, value), 1'b0, 8'h00);
                    value = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(140, 160));
                    push_request(make_request(CMD_WRITE, PORT_LCMP, value), 1'b0, 8'h00);
                    value = {7'($urandom), 1'($urandom_range(0, 4) != 0)};
                    push_request(make_request(CMD_WRITE, PORT_LCD_CTRL, value), 1'b0, 8'h00);
                    value = {7'($urandom), 1'($urandom_range(0, 5) == 0)};
                    push_request(make_request(CMD_WRITE, PORT_LCD_STAT, value), 1'b0, 8'h00);
                    push_request(make_request(CMD_MODE, 8'($urandom), 8'($urandom)),
                                 1'b0, 8'h00);
                    run_items($urandom_range(60, 220), 75, 1'b0);
                end else if (kind < 60) begin
                    // short frames, mostly handed over at the wrap
                    value = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6))
                                                        : 8'($urandom_range(0, LINE_HANDOVER));
                    push_request(make_request(CMD_WRITE, PORT_LAST_LN, value), 1'b0, 8'h00);
                    push_request(make_request(CMD_WRITE, PORT_LCMP, 8'($urandom_range(0, 7))),
                                 1'b0, 8'h00);
                    run_items($urandom_range(30, 90), 55, 1'b0);
                end else if (kind < 75) begin
                    // icon window: frames of one or two lines, status polled as the frames go by
                    value = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
                    push_request(make_request(CMD_WRITE, PORT_LAST_LN, value), 1'b0, 8'h00);
                    push_request(make_request(CMD_VOL, 8'($urandom), 8'($urandom)),
                                 1'b0, 8'h00);
                    run_items($urandom_range(150, 200), 80, 1'b1);
                end else begin
                    run_items($urandom_range(20, 60), 15, 1'b0);
                end
            end
        end

        wait_until_idle();
        if (pending_results.size() != 0) begin
            flag_mismatch("results never delivered", 32'd0, pending_results.size());
        end
        $display("covered %0d requests under %0d model/audio settings, %0d results checked",
                 requests_done, PHASES, results_checked);
        $display("%0d frames handed over (%0d blanked), %0d wraps, %0d vblank, %0d line irq",
                 frames_handed, frames_blanked, wraps_seen, vblanks_seen, line_hits_seen);
        if (mismatches == 0) begin
            $display("[lcd_video_register_and_line_timing] OK");
        end else begin
            $display("[lcd_video_register_and_line_timing] ERROR");
        end
        $finish;
    end

    // Result side: random back-pressure, compare against the oldest expectation
    initial begin : result_sink
        t_video_result want;
        int            stall;
        forever begin
            stall = rsp_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                flag_mismatch("unrequested result read_data", rsp_ch.read_data, 'x);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                    flag_mismatch("read_data", rsp_ch.read_data, want.read_data);
                if (rsp_ch.vblank_irq !== want.vblank)
                    flag_mismatch("vblank_irq", rsp_ch.vblank_irq, want.vblank);
                if (rsp_ch.line_irq !== want.line_hit)
                    flag_mismatch("line_irq", rsp_ch.line_irq, want.line_hit);
                if (rsp_ch.frame_done !== want.frame_done)
                    flag_mismatch("frame_done", rsp_ch.frame_done, want.frame_done);
                if (rsp_ch.frame_blank !== want.blank)
                    flag_mismatch("frame_blank", rsp_ch.frame_blank, want.blank);
                if (rsp_ch.frame_start !== want.frame_start)
                    flag_mismatch("frame_start", rsp_ch.frame_start, want.frame_start);
                if (rsp_ch.current_mode !== want.mode)
                    flag_mismatch("current_mode", rsp_ch.current_mode, want.mode);
            end
            results_checked++;
        end
    end

    // Watchdog: cycles without any request, result or config traffic
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || psel === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no traffic for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_results.size());
            $display("[lcd_video_register_and_line_timing] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
